FILE: rtl/rgsw_pkg.sv
// Shared widths, constants and register codes of the radial gaussian spectrum weight core.
`default_nettype none

package rgsw_pkg;

  // Sample and frame geometry
  localparam int SAMPLE_W  = 32;
  localparam int IDX_W     = 10;
  localparam int DIM_W     = 11;
  localparam int HALF_W    = 10;
  localparam int SPREAD_W  = 16;
  localparam logic [DIM_W-1:0] MAX_DIM = 11'd1024;

  // Configuration port
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 16;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPREAD       = 2'd2;
  localparam logic [DIM_W-1:0]    FRAME_WIDTH_RST  = 11'd512;
  localparam logic [DIM_W-1:0]    FRAME_HEIGHT_RST = 11'd512;
  localparam logic [SPREAD_W-1:0] SPREAD_RST       = 16'd2048;

  // Distance stage: squared radius, root, exponent division
  localparam int DELTA_W     = 11;
  localparam int SQ_W        = 22;
  localparam int FRAC_SH     = 16;
  localparam int ROOT_W      = 19;
  localparam int SQRT_STAGES = 19;
  localparam int S2_W        = 32;
  localparam int SCALE_SH    = 23;
  localparam int NUM_W       = 43;
  localparam int QUO_W       = 21;
  localparam int X16_W       = 21;
  localparam logic [X16_W-1:0] X16_CAP = 21'h100000;
  localparam int DIV_STEPS   = 21;
  localparam int DIV_STAGES  = DIV_STEPS + 2;
  localparam int DIST_LAT    = SQRT_STAGES + DIV_STAGES;

  // Weight stage: range reduction and exp series
  localparam int X32_W        = 37;
  localparam logic [31:0] LN2_Q32 = 32'd2977044472;
  localparam int N_W          = 5;
  localparam int RED_STAGES   = 5;
  localparam int SERIES_TERMS = 13;
  localparam int SER_STAGES   = 3 * (SERIES_TERMS - 1);
  localparam int EXP_LAT      = RED_STAGES + 1 + SER_STAGES + 1;
  localparam int SUM_W        = 34;
  localparam int W_W          = 17;
  localparam logic [W_W-1:0] WEIGHT_ONE = 17'd65536;

  // Sample delay line, aligned with the weight register
  localparam int SMP_DEPTH = 2 + DIST_LAT + EXP_LAT;
  localparam int PROD_W    = SAMPLE_W + W_W + 1;

endpackage

`default_nettype wire

FILE: rtl/rgsw_if.sv
// Valid/ready stream interfaces for spectrum samples and weighted results.
`default_nettype none

interface rgsw_in_if;
  logic                                valid;
  logic                                ready;
  logic [rgsw_pkg::IDX_W-1:0]          row_index;
  logic [rgsw_pkg::IDX_W-1:0]          col_index;
  logic signed [rgsw_pkg::SAMPLE_W-1:0] real_in;
  logic signed [rgsw_pkg::SAMPLE_W-1:0] imag_in;

  modport source (output valid, output row_index, output col_index, output real_in,
                  output imag_in, input ready);
  modport sink (input valid, input row_index, input col_index, input real_in,
                input imag_in, output ready);
endinterface

interface rgsw_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [rgsw_pkg::SAMPLE_W-1:0] real_out;
  logic signed [rgsw_pkg::SAMPLE_W-1:0] imag_out;

  modport source (output valid, output real_out, output imag_out, input ready);
  modport sink (input valid, input real_out, input imag_out, output ready);
endinterface

`default_nettype wire

FILE: rtl/rgsw_dist.sv
// Pipelined square root of the radius, division of it by the spread squared, capped at 16.0.
`default_nettype none

module rgsw_dist (
  input  wire logic                           clk,
  input  wire logic                           en,
  input  wire logic [rgsw_pkg::SQ_W-1:0]      dist_sq,
  input  wire logic [rgsw_pkg::S2_W-1:0]      spread_sq,
  output logic      [rgsw_pkg::X16_W-1:0]     x16
);

  localparam int REM_W = rgsw_pkg::ROOT_W + 2;
  localparam int V_W   = 2 * rgsw_pkg::SQRT_STAGES;

  logic [rgsw_pkg::ROOT_W-1:0] sq_root [rgsw_pkg::SQRT_STAGES];
  logic [REM_W-1:0]            sq_rem  [rgsw_pkg::SQRT_STAGES];
  logic [rgsw_pkg::SQ_W-1:0]   sq_val  [rgsw_pkg::SQRT_STAGES];

  logic [rgsw_pkg::NUM_W-1:0]  dv_num [rgsw_pkg::DIV_STEPS+1];
  logic                        dv_ovf [rgsw_pkg::DIV_STEPS+1];
  logic [rgsw_pkg::S2_W-1:0]   dv_rem [rgsw_pkg::DIV_STEPS+1];
  logic [rgsw_pkg::QUO_W-1:0]  dv_quo [rgsw_pkg::DIV_STEPS+1];

  logic [rgsw_pkg::NUM_W-1:0]  num;

  // Square root of dist_sq * 2^16, one root bit per stage
  for (genvar j = 0; j < rgsw_pkg::SQRT_STAGES; j++) begin : g_sqrt
    localparam int P = rgsw_pkg::SQRT_STAGES - 1 - j;
    logic [rgsw_pkg::ROOT_W-1:0] root_i;
    logic [REM_W-1:0]            rem_i;
    logic [rgsw_pkg::SQ_W-1:0]   val_i;
    logic [V_W-1:0]              v;
    logic [REM_W+1:0]            acc;
    logic [REM_W+1:0]            trial;
    if (j == 0) begin : g_first
      assign root_i = '0;
      assign rem_i  = '0;
      assign val_i  = dist_sq;
    end else begin : g_next
      assign root_i = sq_root[j-1];
      assign rem_i  = sq_rem[j-1];
      assign val_i  = sq_val[j-1];
    end
    assign v     = {val_i, {(V_W-rgsw_pkg::SQ_W){1'b0}}};
    assign acc   = {rem_i, v[2*P+1 -: 2]};
    assign trial = {1'b0, root_i, 2'b01};
    always_ff @(posedge clk) begin
      if (en) begin
        sq_val[j] <= val_i;
        if (acc >= trial) begin
          sq_rem[j]  <= REM_W'(acc - trial);
          sq_root[j] <= {root_i[rgsw_pkg::ROOT_W-2:0], 1'b1};
        end else begin
          sq_rem[j]  <= acc[REM_W-1:0];
          sq_root[j] <= {root_i[rgsw_pkg::ROOT_W-2:0], 1'b0};
        end
      end
    end
  end

  // Form the rounded numerator and flag quotients too wide for the quotient register
  assign num = {1'b0, sq_root[rgsw_pkg::SQRT_STAGES-1], {rgsw_pkg::SCALE_SH{1'b0}}}
             + rgsw_pkg::NUM_W'(spread_sq >> 1);

  always_ff @(posedge clk) begin
    if (en) begin
      dv_num[0] <= num;
      dv_ovf[0] <= rgsw_pkg::S2_W'(num[rgsw_pkg::NUM_W-1:rgsw_pkg::QUO_W]) >= spread_sq;
      dv_rem[0] <= rgsw_pkg::S2_W'(num[rgsw_pkg::NUM_W-1:rgsw_pkg::QUO_W]);
      dv_quo[0] <= '0;
    end
  end

  // Restoring division, one quotient bit per stage
  for (genvar i = 1; i <= rgsw_pkg::DIV_STEPS; i++) begin : g_div
    localparam int B = rgsw_pkg::DIV_STEPS - i;
    logic [rgsw_pkg::S2_W:0] t;
    logic                    ge;
    assign t  = {dv_rem[i-1], dv_num[i-1][B]};
    assign ge = t >= {1'b0, spread_sq};
    always_ff @(posedge clk) begin
      if (en) begin
        dv_num[i] <= dv_num[i-1];
        dv_ovf[i] <= dv_ovf[i-1];
        dv_rem[i] <= ge ? rgsw_pkg::S2_W'(t - {1'b0, spread_sq}) : t[rgsw_pkg::S2_W-1:0];
        dv_quo[i] <= {dv_quo[i-1][rgsw_pkg::QUO_W-2:0], ge};
      end
    end
  end

  // Cap the exponent at 16.0
  always_ff @(posedge clk) begin
    if (en) begin
      if (dv_ovf[rgsw_pkg::DIV_STEPS] || dv_quo[rgsw_pkg::DIV_STEPS] > rgsw_pkg::X16_CAP) begin
        x16 <= rgsw_pkg::X16_CAP;
      end else begin
        x16 <= dv_quo[rgsw_pkg::DIV_STEPS];
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/rgsw_exp.sv
// Pipelined exp(-x) weight: ln 2 range reduction, truncated series, rounding shift.
`default_nettype none

module rgsw_exp (
  input  wire logic                        clk,
  input  wire logic                        en,
  input  wire logic [rgsw_pkg::X16_W-1:0]  x16,
  output logic      [rgsw_pkg::W_W-1:0]    weight
);

  localparam int NS = rgsw_pkg::SER_STAGES;

  logic [rgsw_pkg::X32_W-1:0] red_rem [rgsw_pkg::RED_STAGES];
  logic [rgsw_pkg::N_W-1:0]   red_n   [rgsw_pkg::RED_STAGES];

  logic [31:0]                ser_x   [NS+1];
  logic [31:0]                ser_qm  [NS+1];
  logic [31:0]                ser_r   [NS+1];
  logic [rgsw_pkg::N_W-1:0]   ser_n   [NS+1];
  logic signed [rgsw_pkg::SUM_W-1:0] ser_sum [NS+1];

  logic [rgsw_pkg::SUM_W-2:0] e;
  logic [39:0]                big;
  logic [5:0]                 sh;

  // Reduce x by multiples of ln 2, one quotient bit per stage
  for (genvar j = 0; j < rgsw_pkg::RED_STAGES; j++) begin : g_red
    localparam int B = rgsw_pkg::RED_STAGES - 1 - j;
    localparam logic [rgsw_pkg::X32_W-1:0] LK =
      rgsw_pkg::X32_W'(rgsw_pkg::LN2_Q32) << B;
    logic [rgsw_pkg::X32_W-1:0] rem_i;
    logic [rgsw_pkg::N_W-1:0]   n_i;
    logic                       ge;
    if (j == 0) begin : g_first
      assign rem_i = {x16, 16'b0};
      assign n_i   = '0;
    end else begin : g_next
      assign rem_i = red_rem[j-1];
      assign n_i   = red_n[j-1];
    end
    assign ge = rem_i >= LK;
    always_ff @(posedge clk) begin
      if (en) begin
        red_rem[j] <= ge ? rem_i - LK : rem_i;
        red_n[j]   <= {n_i[rgsw_pkg::N_W-2:0], ge};
      end
    end
  end

  // Start the series: first term is r, sum is 1 - r
  always_ff @(posedge clk) begin
    if (en) begin
      ser_x[0]   <= red_rem[rgsw_pkg::RED_STAGES-1][31:0];
      ser_r[0]   <= red_rem[rgsw_pkg::RED_STAGES-1][31:0];
      ser_n[0]   <= red_n[rgsw_pkg::RED_STAGES-1];
      ser_qm[0]  <= '0;
      ser_sum[0] <= rgsw_pkg::SUM_W'(64'h1_0000_0000)
                  - rgsw_pkg::SUM_W'(red_rem[rgsw_pkg::RED_STAGES-1][31:0]);
    end
  end

  // Each term: multiply by r, divide by k through a reciprocal, correct, accumulate
  for (genvar s = 1; s <= NS; s++) begin : g_ser
    localparam int PH = (s - 1) % 3;
    localparam int KV = (s - 1) / 3 + 2;
    localparam longint unsigned MK = 64'h1_0000_0000 / KV;
    if (PH == 0) begin : g_mul
      logic [63:0] prod;
      assign prod = {32'b0, ser_x[s-1]} * {32'b0, ser_r[s-1]};
      always_ff @(posedge clk) begin
        if (en) begin
          ser_x[s]   <= prod[63:32];
          ser_qm[s]  <= '0;
          ser_r[s]   <= ser_r[s-1];
          ser_n[s]   <= ser_n[s-1];
          ser_sum[s] <= ser_sum[s-1];
        end
      end
    end else if (PH == 1) begin : g_recip
      logic [63:0] prod;
      assign prod = {32'b0, ser_x[s-1]} * 64'(MK[31:0]);
      always_ff @(posedge clk) begin
        if (en) begin
          ser_x[s]   <= ser_x[s-1];
          ser_qm[s]  <= prod[63:32];
          ser_r[s]   <= ser_r[s-1];
          ser_n[s]   <= ser_n[s-1];
          ser_sum[s] <= ser_sum[s-1];
        end
      end
    end else begin : g_fix
      logic [35:0] diff;
      logic [31:0] term;
      assign diff = {4'b0, ser_x[s-1]} - 36'(ser_qm[s-1]) * 36'(KV);
      assign term = ser_qm[s-1] + 32'(diff >= 36'(KV));
      always_ff @(posedge clk) begin
        if (en) begin
          ser_x[s]  <= term;
          ser_qm[s] <= '0;
          ser_r[s]  <= ser_r[s-1];
          ser_n[s]  <= ser_n[s-1];
          if (KV % 2 == 1) begin
            ser_sum[s] <= ser_sum[s-1] - rgsw_pkg::SUM_W'(term);
          end else begin
            ser_sum[s] <= ser_sum[s-1] + rgsw_pkg::SUM_W'(term);
          end
        end
      end
    end
  end

  // Clamp, scale by 2^-n and round to Q1.16
  assign e   = ser_sum[NS][rgsw_pkg::SUM_W-1] ? '0 : ser_sum[NS][rgsw_pkg::SUM_W-2:0];
  assign sh  = {1'b0, ser_n[NS]} + 6'd16;
  assign big = 40'(e) + (40'd1 << (sh - 6'd1));

  always_ff @(posedge clk) begin
    if (en) begin
      weight <= rgsw_pkg::W_W'(big >> sh);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/radial_gaussian_spectrum_weight_core.sv
// Top level: radial gaussian lowpass weight applied to a stream of complex spectrum words.
//
//   channel  | dir | handshake      | word
//   ---------+-----+----------------+---------------------------------------------
//   sample   | in  | valid/ready    | row_index, col_index, real_in, imag_in
//   result   | out | valid/ready    | real_out, imag_out
//   cfg      | in  | cfg_write only | cfg_index, cfg_data (frame_width/height, spread)
//
// One word enters per cycle unless a finished word waits at a stalled result. The pipeline
// holds the root (19 stages), the exponent divider (23 stages), the exp stage (43 stages)
// and four stages of geometry, product and rounding.
// A stall at the result freezes the whole pipeline in place; nothing drops or repeats.
// Reset clears the valid bits and loads the register reset values.
`default_nettype none

module radial_gaussian_spectrum_weight_core (
  input  wire logic                             clk,
  input  wire logic                             rst,
  rgsw_in_if.sink                               sample,
  rgsw_out_if.source                            result,
  input  wire logic                             cfg_write,
  input  wire logic [rgsw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [rgsw_pkg::CFG_W-1:0]       cfg_data
);

  localparam int D = rgsw_pkg::SMP_DEPTH;

  logic [rgsw_pkg::DIM_W-1:0]    frame_width;
  logic [rgsw_pkg::DIM_W-1:0]    frame_height;
  logic [rgsw_pkg::SPREAD_W-1:0] spread;
  logic [rgsw_pkg::S2_W-1:0]     spread_sq;
  logic [rgsw_pkg::SPREAD_W-1:0] spread_eff;
  logic [rgsw_pkg::DIM_W-1:0]    w_dim;
  logic [rgsw_pkg::DIM_W-1:0]    h_dim;
  logic [rgsw_pkg::HALF_W-1:0]   half_w;
  logic [rgsw_pkg::HALF_W-1:0]   half_h;

  logic                          en;
  logic signed [rgsw_pkg::DELTA_W-1:0] dy;
  logic signed [rgsw_pkg::DELTA_W-1:0] dx;
  logic [rgsw_pkg::SQ_W-1:0]     dist_sq;
  logic [rgsw_pkg::X16_W-1:0]    x16;
  logic [rgsw_pkg::W_W-1:0]      weight;

  logic                          vld    [D];
  logic signed [rgsw_pkg::SAMPLE_W-1:0] smp_re [D];
  logic signed [rgsw_pkg::SAMPLE_W-1:0] smp_im [D];

  logic                          prod_vld;
  logic signed [rgsw_pkg::PROD_W-1:0] prod_re;
  logic signed [rgsw_pkg::PROD_W-1:0] prod_im;
  logic                          out_vld;

  // Round half up by 2^16 and saturate to the sample range
  function automatic logic signed [rgsw_pkg::SAMPLE_W-1:0] round_sat(
    input logic signed [rgsw_pkg::PROD_W-1:0] p
  );
    logic signed [rgsw_pkg::PROD_W:0]    s;
    logic signed [rgsw_pkg::PROD_W-16:0] q;
    logic signed [rgsw_pkg::PROD_W-16:0] hi;
    logic signed [rgsw_pkg::PROD_W-16:0] lo;
    s  = {p[rgsw_pkg::PROD_W-1], p} + (rgsw_pkg::PROD_W+1)'(32768);
    q  = (rgsw_pkg::PROD_W-15)'(s >>> 16);
    hi = (rgsw_pkg::PROD_W-15)'({1'b0, {(rgsw_pkg::SAMPLE_W-1){1'b1}}});
    lo = -hi - (rgsw_pkg::PROD_W-15)'(1);
    if (q > hi) begin
      return hi[rgsw_pkg::SAMPLE_W-1:0];
    end else if (q < lo) begin
      return lo[rgsw_pkg::SAMPLE_W-1:0];
    end
    return q[rgsw_pkg::SAMPLE_W-1:0];
  endfunction

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= rgsw_pkg::FRAME_WIDTH_RST;
      frame_height <= rgsw_pkg::FRAME_HEIGHT_RST;
      spread       <= rgsw_pkg::SPREAD_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        rgsw_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data[rgsw_pkg::DIM_W-1:0];
        rgsw_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data[rgsw_pkg::DIM_W-1:0];
        rgsw_pkg::REG_SPREAD:       spread       <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Frame centre and spread squared
  assign w_dim      = frame_width > rgsw_pkg::MAX_DIM ? rgsw_pkg::MAX_DIM : frame_width;
  assign h_dim      = frame_height > rgsw_pkg::MAX_DIM ? rgsw_pkg::MAX_DIM : frame_height;
  assign half_w     = w_dim[rgsw_pkg::DIM_W-1:1];
  assign half_h     = h_dim[rgsw_pkg::DIM_W-1:1];
  assign spread_eff = spread == '0 ? rgsw_pkg::SPREAD_W'(1) : spread;

  always_ff @(posedge clk) begin
    spread_sq <= rgsw_pkg::S2_W'(spread_eff) * rgsw_pkg::S2_W'(spread_eff);
  end

  // Advance everything unless a finished word waits at the output
  assign en           = !out_vld || result.ready;
  assign sample.ready = en;

  // Offsets from the centre, then squared radius
  always_ff @(posedge clk) begin
    if (en) begin
      dy      <= $signed({1'b0, sample.row_index}) - $signed({1'b0, half_h});
      dx      <= $signed({1'b0, sample.col_index}) - $signed({1'b0, half_w});
      dist_sq <= rgsw_pkg::SQ_W'(dy * dy) + rgsw_pkg::SQ_W'(dx * dx);
    end
  end

  rgsw_dist u_dist (
    .clk       (clk),
    .en        (en),
    .dist_sq   (dist_sq),
    .spread_sq (spread_sq),
    .x16       (x16)
  );

  rgsw_exp u_exp (
    .clk    (clk),
    .en     (en),
    .x16    (x16),
    .weight (weight)
  );

  // Carry samples and valid bits alongside the weight computation
  always_ff @(posedge clk) begin
    if (en) begin
      smp_re[0] <= sample.real_in;
      smp_im[0] <= sample.imag_in;
      for (int i = 1; i < D; i++) begin
        smp_re[i] <= smp_re[i-1];
        smp_im[i] <= smp_im[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < D; i++) begin
        vld[i] <= 1'b0;
      end
      prod_vld <= 1'b0;
      out_vld  <= 1'b0;
    end else if (en) begin
      vld[0] <= sample.valid;
      for (int i = 1; i < D; i++) begin
        vld[i] <= vld[i-1];
      end
      prod_vld <= vld[D-1];
      out_vld  <= prod_vld;
    end
  end

  // Scale both parts by the weight, then round and saturate
  always_ff @(posedge clk) begin
    if (en) begin
      prod_re <= rgsw_pkg::PROD_W'(smp_re[D-1]) * $signed({1'b0, weight});
      prod_im <= rgsw_pkg::PROD_W'(smp_im[D-1]) * $signed({1'b0, weight});
      result.real_out <= round_sat(prod_re);
      result.imag_out <= round_sat(prod_im);
    end
  end

  assign result.valid = out_vld;

`ifndef ASSERT_OFF
  // Weight of a valid word never exceeds 1.0
  a_weight_max: assert property (@(posedge clk) disable iff (rst)
    vld[D-1] |-> weight <= rgsw_pkg::WEIGHT_ONE)
    else $error("weight above 1.0");
`endif

`ifndef ASSERT_OFF
  // Exponent of a valid word is capped at 16.0
  a_x16_cap: assert property (@(posedge clk) disable iff (rst)
    vld[rgsw_pkg::DIST_LAT+1] |-> x16 <= rgsw_pkg::X16_CAP)
    else $error("exponent above cap");
`endif

`ifndef ASSERT_OFF
  // A stall freezes the valid line at the product and output
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(prod_vld) && $stable(vld[D-1]) && out_vld)
    else $error("pipeline moved during stall");
`endif

`ifndef ASSERT_OFF
  // No result right after reset
  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !result.valid)
    else $error("result valid after reset");
`endif

endmodule

`default_nettype wire
